// File: rtl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned DIM_W  = 13;  // width, height, crop_w, crop_h
  localparam int unsigned POS_W  = 12;  // crop_x, crop_y, row counter
  localparam int unsigned COL_W  = 14;  // byte column within a source row
  localparam int unsigned HI_W   = 16;  // window end in bytes
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PAD_W  = 2;

  localparam logic [DIM_W-1:0] MAX_W_C = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_C = DIM_W'(MAX_HEIGHT);
  localparam logic [COL_W-1:0] MAX_ROW_BYTES = COL_W'(3 * MAX_WIDTH);

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_CROP_X     = 3'd2,
    REG_CROP_Y     = 3'd3,
    REG_CROP_W     = 3'd4,
    REG_CROP_H     = 3'd5
  } reg_idx_t;

  // pending results of one accepted byte
  typedef struct packed {
    logic              has_data;
    logic [PAD_W-1:0]  npad;
    logic              top;
    logic [BYTE_W-1:0] data;
  } grp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bmp_stream_crop.sv
`default_nettype none

// Channel | Dir | Ports                               | Meaning
// in_     | in  | tvalid, tready, tdata[7:0]          | source pixel bytes, stored order
// out_    | out | tvalid, tready, tdata[7:0], tuser, tlast | cropped bytes, row padding
// cfg_    | in  | wen, index[2:0], wdata[12:0]        | register writes
//
// One source byte is accepted per cycle while the skid stage is empty; a kept byte
// ending a window row adds up to 3 padding transfers, which stall the input until sent.
// The output register is loaded at the accepting edge when it is free.
// in_tready is decoded from the skid stage registers; a stalled output parks one
// byte group in the skid stage and drops in_tready until it drains.
// rst_n is synchronous: counters go to zero, registers to a 1x1 image and window.

module bmp_stream_crop (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  input  wire logic [bsc_pkg::BYTE_W-1:0] in_tdata,   // [7:0] src_byte
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  output      logic [bsc_pkg::BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output      logic                       out_tuser,  // [0] is_padding
  output      logic                       out_tlast,
  input  wire logic                       cfg_wen,
  input  wire logic [bsc_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [bsc_pkg::DIM_W-1:0]  cfg_wdata
);

  logic [bsc_pkg::DIM_W-1:0] src_width_r, src_height_r, crop_w_r, crop_h_r;
  logic [bsc_pkg::POS_W-1:0] crop_x_r, crop_y_r;

  logic [bsc_pkg::COL_W-1:0] byte_column_r, byte_column_nxt;
  logic [bsc_pkg::POS_W-1:0] row_count_r, row_count_nxt;

  bsc_pkg::grp_t grp_r, grp_nxt;
  logic grp_busy;

  logic                       out_valid_r, out_valid_nxt;
  logic [bsc_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                       out_pad_r, out_pad_nxt;
  logic                       out_last_r, out_last_nxt;

  // position and window
  logic [bsc_pkg::DIM_W-1:0] w, h;
  logic [bsc_pkg::COL_W-1:0] data_bytes, row_size, c_eff, c_inc;
  logic [bsc_pkg::POS_W-1:0] rc_eff, rc_inc, ty;
  logic [bsc_pkg::DIM_W-1:0] ty_ext;
  logic [bsc_pkg::COL_W-1:0] win_lo, xw_sum;
  logic [bsc_pkg::HI_W-1:0]  win_hi;
  logic row_in, top_row, keep, row_end;
  logic [bsc_pkg::PAD_W-1:0] npad;
  logic accept, o_free;

  always_comb begin
    w = bsc_pkg::clamp_dim(src_width_r, bsc_pkg::MAX_W_C);
    h = bsc_pkg::clamp_dim(src_height_r, bsc_pkg::MAX_H_C);
    data_bytes = {w[bsc_pkg::COL_W-2:0], 1'b0} + bsc_pkg::COL_W'(w);
    row_size   = data_bytes + bsc_pkg::COL_W'(w[1:0]);

    if (bsc_pkg::DIM_W'(row_count_r) >= h) rc_eff = bsc_pkg::POS_W'(h - 1'b1);
    else rc_eff = row_count_r;
    if (byte_column_r >= row_size) c_eff = row_size - 1'b1;
    else c_eff = byte_column_r;

    ty_ext  = h - 1'b1 - bsc_pkg::DIM_W'(rc_eff);
    ty      = ty_ext[bsc_pkg::POS_W-1:0];
    row_in  = (crop_h_r != '0) && (ty >= crop_y_r) &&
              (bsc_pkg::DIM_W'(ty - crop_y_r) < crop_h_r);
    top_row = (ty == crop_y_r);

    win_lo = {1'b0, crop_x_r, 1'b0} + bsc_pkg::COL_W'(crop_x_r);
    xw_sum = bsc_pkg::COL_W'(crop_x_r) + bsc_pkg::COL_W'(crop_w_r);
    win_hi = {1'b0, xw_sum, 1'b0} + bsc_pkg::HI_W'(xw_sum);

    keep    = row_in && (crop_w_r != '0) && (c_eff < data_bytes) &&
              (c_eff >= win_lo) && (bsc_pkg::HI_W'(c_eff) < win_hi);
    row_end = (bsc_pkg::HI_W'(c_eff) + 1'b1) == win_hi;
    npad    = row_end ? crop_w_r[1:0] : '0;

    c_inc  = c_eff + 1'b1;
    rc_inc = rc_eff + 1'b1;
    if (c_inc >= row_size) begin
      byte_column_nxt = '0;
      row_count_nxt   = (bsc_pkg::DIM_W'(rc_eff) + 1'b1 >= h) ? '0 : rc_inc;
    end else begin
      byte_column_nxt = c_inc;
      row_count_nxt   = rc_eff;
    end
  end

  assign grp_busy  = grp_r.has_data || (grp_r.npad != '0);
  assign in_tready = !grp_busy;
  assign accept    = in_tvalid && in_tready;
  assign o_free    = !out_valid_r || out_tready;

  always_comb begin
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_pad_nxt   = out_pad_r;
    out_last_nxt  = out_last_r;
    if (grp_busy) begin
      if (o_free) begin
        out_valid_nxt = 1'b1;
        if (grp_r.has_data) begin
          out_data_nxt     = grp_r.data;
          out_pad_nxt      = 1'b0;
          out_last_nxt     = grp_r.top && (grp_r.npad == '0);
          grp_nxt.has_data = 1'b0;
        end else begin
          out_data_nxt = '0;
          out_pad_nxt  = 1'b1;
          out_last_nxt = grp_r.top && (grp_r.npad == bsc_pkg::PAD_W'(1));
          grp_nxt.npad = grp_r.npad - 1'b1;
        end
      end
    end else if (accept && keep) begin
      grp_nxt.npad = npad;
      grp_nxt.top  = top_row && row_end;
      grp_nxt.data = in_tdata;
      if (o_free) begin
        out_valid_nxt    = 1'b1;
        out_data_nxt     = in_tdata;
        out_pad_nxt      = 1'b0;
        out_last_nxt     = top_row && row_end && (npad == '0);
        grp_nxt.has_data = 1'b0;
      end else begin
        grp_nxt.has_data = 1'b1;
      end
    end else if (o_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= bsc_pkg::DIM_W'(1);
      src_height_r  <= bsc_pkg::DIM_W'(1);
      crop_x_r      <= '0;
      crop_y_r      <= '0;
      crop_w_r      <= bsc_pkg::DIM_W'(1);
      crop_h_r      <= bsc_pkg::DIM_W'(1);
      byte_column_r <= '0;
      row_count_r   <= '0;
      grp_r.has_data <= 1'b0;
      grp_r.npad    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (bsc_pkg::reg_idx_t'(cfg_index))
          bsc_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
          bsc_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
          bsc_pkg::REG_CROP_X:     crop_x_r     <= cfg_wdata[bsc_pkg::POS_W-1:0];
          bsc_pkg::REG_CROP_Y:     crop_y_r     <= cfg_wdata[bsc_pkg::POS_W-1:0];
          bsc_pkg::REG_CROP_W:     crop_w_r     <= cfg_wdata;
          bsc_pkg::REG_CROP_H:     crop_h_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        byte_column_r <= byte_column_nxt;
        row_count_r   <= row_count_nxt;
      end
      grp_r          <= grp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_pad_r  <= out_pad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pad_r;
  assign out_tlast  = out_last_r;

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("padding transfer with nonzero data");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> byte_column_r < bsc_pkg::MAX_ROW_BYTES)
    else $error("byte column beyond largest row");

  a_park_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r.has_data |-> out_valid_r)
    else $error("data parked while output register empty");

  a_grp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    grp_busy && out_valid_r && !out_tready |=> $stable(grp_r.npad) &&
      $stable(grp_r.has_data))
    else $error("skid group changed during output stall");

endmodule

`default_nettype wire

// File: tb/sv/bmp_stream_crop_checker.sv
module bmp_stream_crop_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [bsc_pkg::BYTE_W-1:0] in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [bsc_pkg::BYTE_W-1:0] out_tdata,
  input  logic                       out_tuser,
  input  logic                       out_tlast,
  input  logic                       cfg_wen,
  input  logic [bsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::DIM_W-1:0]  cfg_wdata,
  output int unsigned                mismatches,
  output int unsigned                crop_pending,
  output int unsigned                crop_checked
);

  typedef struct packed {
    logic [bsc_pkg::BYTE_W-1:0] data;
    logic                       pad;
    logic                       last;
  } crop_byte_t;

  crop_byte_t crop_q[$];
  crop_byte_t want;

  logic [bsc_pkg::DIM_W-1:0] src_w, src_h, win_w, win_h;
  logic [bsc_pkg::POS_W-1:0] win_x, win_y;
  logic [bsc_pkg::COL_W-1:0] col_pos;
  logic [bsc_pkg::POS_W-1:0] src_row;

  initial begin
    mismatches   = 0;
    crop_pending = 0;
    crop_checked = 0;
  end

  function automatic int unsigned row_pad(input int unsigned px);
    return (4 - (px * 3) % 4) % 4;
  endfunction

  function automatic int unsigned clip_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // expected output bytes for one accepted source byte; advances the position
  task automatic crop_byte(input logic [bsc_pkg::BYTE_W-1:0] d);
    int unsigned w, h, data_bytes, row_size, c, r, ty, lo, hi, npad, k;
    logic row_in, row_end, top;
    crop_byte_t e;
    w = clip_dim(src_w, bsc_pkg::MAX_WIDTH);
    h = clip_dim(src_h, bsc_pkg::MAX_HEIGHT);
    data_bytes = 3 * w;
    row_size = data_bytes + row_pad(w);
    c = col_pos;
    r = src_row;
    if (r >= h) r = h - 1;
    if (c >= row_size) c = row_size - 1;
    ty = h - 1 - r;
    row_in = (win_h != 0) && (ty >= win_y) && (ty - win_y < win_h);
    top = (ty == win_y);
    lo = 3 * win_x;
    hi = 3 * (win_x + win_w);
    if (row_in && win_w != 0 && c < data_bytes && c >= lo && c < hi) begin
      row_end = (c == hi - 1);
      npad = row_end ? row_pad(win_w) : 0;
      e.data = d;
      e.pad = 1'b0;
      e.last = row_end && top && npad == 0;
      crop_q.push_back(e);
      for (k = 0; k < npad; k++) begin
        e.data = '0;
        e.pad = 1'b1;
        e.last = top && (k == npad - 1);
        crop_q.push_back(e);
      end
    end
    if (c + 1 >= row_size) begin
      col_pos = '0;
      src_row = (r + 1 >= h) ? '0 : bsc_pkg::POS_W'(r + 1);
    end else begin
      col_pos = bsc_pkg::COL_W'(c + 1);
      src_row = bsc_pkg::POS_W'(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      src_w = bsc_pkg::DIM_W'(1);
      src_h = bsc_pkg::DIM_W'(1);
      win_w = bsc_pkg::DIM_W'(1);
      win_h = bsc_pkg::DIM_W'(1);
      win_x = '0;
      win_y = '0;
      col_pos = '0;
      src_row = '0;
      crop_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          bsc_pkg::REG_SRC_WIDTH:  src_w = cfg_wdata;
          bsc_pkg::REG_SRC_HEIGHT: src_h = cfg_wdata;
          bsc_pkg::REG_CROP_X:     win_x = cfg_wdata[bsc_pkg::POS_W-1:0];
          bsc_pkg::REG_CROP_Y:     win_y = cfg_wdata[bsc_pkg::POS_W-1:0];
          bsc_pkg::REG_CROP_W:     win_w = cfg_wdata;
          bsc_pkg::REG_CROP_H:     win_h = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) crop_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (crop_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual data %02h pad %0b last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          want = crop_q.pop_front();
          crop_checked++;
          if (want.data !== out_tdata) begin
            $display("%0t out_tdata mismatch: expected %02h actual %02h",
                     $time, want.data, out_tdata);
            mismatches++;
          end
          if (want.pad !== out_tuser) begin
            $display("%0t out_tuser mismatch: expected %0b actual %0b",
                     $time, want.pad, out_tuser);
            mismatches++;
          end
          if (want.last !== out_tlast) begin
            $display("%0t out_tlast mismatch: expected %0b actual %0b",
                     $time, want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    crop_pending <= crop_q.size();
  end

endmodule

// File: tb/sv/bmp_stream_crop_tb.sv
module bmp_stream_crop_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RAND_BYTES  = 90;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [bsc_pkg::BYTE_W-1:0] in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [bsc_pkg::BYTE_W-1:0] out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;
  logic                       cfg_wen = 1'b0;
  logic [bsc_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [bsc_pkg::DIM_W-1:0]  cfg_wdata = '0;

  int unsigned mismatches, crop_pending, crop_checked;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings = 1;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  bmp_stream_crop u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bmp_stream_crop_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .crop_pending (crop_pending),
    .crop_checked (crop_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d transfers outstanding", cycles, crop_pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // output side: random stalls, one long hold-off on request, none when quiet
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input bsc_pkg::reg_idx_t idx,
                           input logic [bsc_pkg::DIM_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [bsc_pkg::DIM_W-1:0] w,
                            input logic [bsc_pkg::DIM_W-1:0] h,
                            input logic [bsc_pkg::DIM_W-1:0] x,
                            input logic [bsc_pkg::DIM_W-1:0] y,
                            input logic [bsc_pkg::DIM_W-1:0] cw,
                            input logic [bsc_pkg::DIM_W-1:0] ch);
    write_reg(bsc_pkg::REG_SRC_WIDTH, w);
    write_reg(bsc_pkg::REG_SRC_HEIGHT, h);
    write_reg(bsc_pkg::REG_CROP_X, x);
    write_reg(bsc_pkg::REG_CROP_Y, y);
    write_reg(bsc_pkg::REG_CROP_W, cw);
    write_reg(bsc_pkg::REG_CROP_H, ch);
    cfg_wen <= 1'b0;
    settings++;
  endtask

  task automatic send_byte(input logic [bsc_pkg::BYTE_W-1:0] d);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_byte(bsc_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // let every expected transfer arrive, then let the pipeline settle
  task automatic drain(input int unsigned extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (crop_pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, x, y, cw, ch, frame_bytes, n, rand_sent, ph;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1x1 image, two frames through the counter wrap
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h55);
    drain(12);

    // zero sizes clamp to one pixel; empty window
    set_window(0, 0, 0, 0, 0, 0);
    send_random(4);
    drain(12);

    // oversize source clamps to max; top row of a full-width window
    set_window(13'h1FFF, 13'h1FFF, 0, 12'hFFF, 13'h1000, 1);
    send_random(4);
    drain(12);

    // window starting past the source, counters left mid-row above
    set_window(1, 1, 12'hFFF, 0, 13'h1FFF, 13'h1FFF);
    send_random(4);
    drain(12);

    // window wider than the source
    set_window(1, 2, 0, 0, 13'h1FFF, 2);
    send_random(4);
    drain(12);

    // two-pixel window, two bytes of output padding
    set_window(2, 1, 0, 0, 2, 1);
    send_random(8);
    drain(12);

    rand_sent = 0;
    ph = 0;
    while (rand_sent < RAND_BYTES) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 3);
      if (ph == 0 || $urandom_range(0, 4) != 0) begin
        x  = $urandom_range(0, w - 1);
        cw = $urandom_range(1, w - x);
        y  = $urandom_range(0, h - 1);
        ch = $urandom_range(1, h - y);
      end else begin
        x  = $urandom_range(0, w + 1);
        cw = $urandom_range(0, w + 2);
        y  = $urandom_range(0, h);
        ch = $urandom_range(0, h + 1);
      end
      set_window(w, h, x, y, cw, ch);
      frame_bytes = (3 * w + (4 - (3 * w) % 4) % 4) * h;
      if (ph == 0) n = frame_bytes * 2;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(1, frame_bytes);
      else n = frame_bytes * $urandom_range(1, 2);
      if (ph == 0) begin
        hold_req = 1'b1;
        wait (!hold_req);
      end
      if (rand_sent >= RAND_BYTES - 30) quiet = 1'b1;
      send_random(n);
      rand_sent += n;
      ph++;
      drain(12);
    end

    drain(20);
    $display("Run covered %0d source bytes under %0d window settings, incl. clamped sizes,",
             bytes_sent, settings);
    $display("empty and out-of-source windows; %0d output bytes checked", crop_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
